@@ hdl/lps_pkg.sv @@
// Package for the line pixel stepper: widths, command codes and the queue item.
// Used by every module of the block and by its port checker.
package lps_pkg;

    localparam int COORD_WIDTH   = 12;
    localparam int ERR_WIDTH     = COORD_WIDTH + 2;
    localparam int COLOUR_WIDTH  = 16;
    localparam int S_TDATA_WIDTH = ((4 * COORD_WIDTH + COLOUR_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((1 + 2 * COORD_WIDTH + COLOUR_WIDTH + 7) / 8) * 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);

    typedef logic [COORD_WIDTH-1:0]        coord_t;
    typedef logic signed [ERR_WIDTH-1:0]   err_t;
    typedef logic [COLOUR_WIDTH-1:0]       colour_t;

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    // Decoded item handed from the front to the back
    typedef struct packed
    {
        cmd_t    cmd;
        coord_t  x0;
        coord_t  y0;
        coord_t  x1;
        coord_t  y1;
        coord_t  dx;
        coord_t  dy;
        logic    sxn;
        logic    syn;
        err_t    err0;
        colour_t colour;
    } lps_item_t;

endpackage

@@ hdl/lps_front.sv @@
// Front end of the line pixel stepper: takes input transfers and decodes them.
// Start commands get their spans, step directions and initial error here. Uses lps_pkg.
module lps_front
(
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: start_x, start_y, end_x, end_y, colour_in (low bits first)
    input  logic [lps_pkg::S_TDATA_WIDTH-1:0]   s_axis_tdata,
    // tuser: command
    input  logic                                s_axis_tuser,
    input  logic                                q_full,
    output logic                                q_push,
    output lps_pkg::lps_item_t                  q_item
);
    import lps_pkg::*;

    coord_t  x0, y0, x1, y1;
    coord_t  dx, dy;
    colour_t colour;

    assign x0     = s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH];
    assign y0     = s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH];
    assign x1     = s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    assign y1     = s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH];
    assign colour = s_axis_tdata[4*COORD_WIDTH +: COLOUR_WIDTH];

    assign dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
    assign dy = (y1 >= y0) ? y1 - y0 : y0 - y1;

    always_comb
    begin
        q_item.cmd    = cmd_t'(s_axis_tuser);
        q_item.x0     = x0;
        q_item.y0     = y0;
        q_item.x1     = x1;
        q_item.y1     = y1;
        q_item.dx     = dx;
        q_item.dy     = dy;
        q_item.sxn    = !(x0 < x1);
        q_item.syn    = !(y0 < y1);
        q_item.err0   = err_t'({2'b00, dx}) - err_t'({2'b00, dy});
        q_item.colour = colour;
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

endmodule

@@ hdl/lps_queue.sv @@
// Short queue between the decode front and the stepping back end.
// Holds decoded items of type lps_item_t from lps_pkg.
module lps_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lps_pkg::lps_item_t push_item,
    output logic               full,
    output logic               pop_valid,
    input  logic               pop,
    output lps_pkg::lps_item_t pop_item
);
    import lps_pkg::*;

    lps_item_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_WIDTH-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QPTR_WIDTH:0]      count_reg, count_next;
    logic                     do_push, do_pop;

    assign full      = (count_reg == (QPTR_WIDTH + 1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/lps_back.sv @@
// Back end of the line pixel stepper: line state, Bresenham step and output register.
// Takes decoded items from lps_queue; uses lps_pkg.
module lps_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               q_pop,
    input  lps_pkg::lps_item_t                 q_item,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: pixel_valid, pixel_x, pixel_y, pixel_colour (low bits first)
    output logic [lps_pkg::M_TDATA_WIDTH-1:0]  m_axis_tdata,
    // tlast: last_pixel
    output logic                               m_axis_tlast
);
    import lps_pkg::*;

    localparam int WIDE = ERR_WIDTH + 1;

    coord_t  cur_x_reg, cur_x_next;
    coord_t  cur_y_reg, cur_y_next;
    coord_t  tgt_x_reg, tgt_x_next;
    coord_t  tgt_y_reg, tgt_y_next;
    coord_t  dx_reg, dx_next;
    coord_t  dy_reg, dy_next;
    logic    sxn_reg, sxn_next;
    logic    syn_reg, syn_next;
    err_t    err_reg, err_next;
    colour_t colour_reg, colour_next;
    logic    busy_reg, busy_next;

    logic    out_valid_reg;
    logic    pix_valid_reg, pix_valid_next;
    coord_t  pix_x_reg, pix_x_next;
    coord_t  pix_y_reg, pix_y_next;
    colour_t pix_colour_reg, pix_colour_next;
    logic    pix_last_reg, pix_last_next;

    logic signed [WIDE-1:0] e2, neg_dy, pos_dx, err_wide, err_sum;
    logic                   take_x, take_y;
    coord_t                 step_x, step_y;
    logic                   at_end;

    assign q_pop = q_valid && (!out_valid_reg || m_axis_tready);

    // Error rule: both tests use the doubled error from before the step
    assign e2       = {err_reg, 1'b0};
    assign neg_dy   = -$signed({2'b00, dy_reg});
    assign pos_dx   = $signed({2'b00, dx_reg});
    assign err_wide = {err_reg[ERR_WIDTH-1], err_reg};
    assign take_x   = e2 > neg_dy;
    assign take_y   = e2 < pos_dx;
    assign err_sum  = err_wide - (take_x ? $signed({2'b00, dy_reg}) : '0)
                               + (take_y ? pos_dx : '0);
    assign step_x   = take_x ? (sxn_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1) : cur_x_reg;
    assign step_y   = take_y ? (syn_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1) : cur_y_reg;

    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        tgt_x_next      = tgt_x_reg;
        tgt_y_next      = tgt_y_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        sxn_next        = sxn_reg;
        syn_next        = syn_reg;
        err_next        = err_reg;
        colour_next     = colour_reg;
        busy_next       = busy_reg;
        pix_valid_next  = pix_valid_reg;
        pix_x_next      = pix_x_reg;
        pix_y_next      = pix_y_reg;
        pix_colour_next = pix_colour_reg;
        pix_last_next   = pix_last_reg;
        at_end          = 1'b0;

        if (q_pop)
        begin
            unique case (q_item.cmd)
                CMD_START:
                begin
                    // drop any running line
                    at_end          = (q_item.x0 == q_item.x1) && (q_item.y0 == q_item.y1);
                    cur_x_next      = q_item.x0;
                    cur_y_next      = q_item.y0;
                    tgt_x_next      = q_item.x1;
                    tgt_y_next      = q_item.y1;
                    dx_next         = q_item.dx;
                    dy_next         = q_item.dy;
                    sxn_next        = q_item.sxn;
                    syn_next        = q_item.syn;
                    err_next        = q_item.err0;
                    colour_next     = q_item.colour;
                    busy_next       = !at_end;
                    pix_valid_next  = 1'b1;
                    pix_x_next      = q_item.x0;
                    pix_y_next      = q_item.y0;
                    pix_colour_next = q_item.colour;
                    pix_last_next   = at_end;
                end
                CMD_STEP:
                begin
                    if (busy_reg)
                    begin
                        at_end          = (step_x == tgt_x_reg) && (step_y == tgt_y_reg);
                        cur_x_next      = step_x;
                        cur_y_next      = step_y;
                        err_next        = err_sum[ERR_WIDTH-1:0];
                        busy_next       = !at_end;
                        pix_valid_next  = 1'b1;
                        pix_x_next      = step_x;
                        pix_y_next      = step_y;
                        pix_colour_next = colour_reg;
                        pix_last_next   = at_end;
                    end
                    else
                    begin
                        pix_valid_next  = 1'b0;
                        pix_x_next      = '0;
                        pix_y_next      = '0;
                        pix_colour_next = '0;
                        pix_last_next   = 1'b0;
                    end
                end
                default:
                begin
                    pix_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        tgt_x_reg      <= tgt_x_next;
        tgt_y_reg      <= tgt_y_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        sxn_reg        <= sxn_next;
        syn_reg        <= syn_next;
        err_reg        <= err_next;
        colour_reg     <= colour_next;
        pix_valid_reg  <= pix_valid_next;
        pix_x_reg      <= pix_x_next;
        pix_y_reg      <= pix_y_next;
        pix_colour_reg <= pix_colour_next;
        pix_last_reg   <= pix_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = pix_last_reg;
    assign m_axis_tdata  = M_TDATA_WIDTH'({pix_colour_reg, pix_y_reg, pix_x_reg, pix_valid_reg});

endmodule

@@ hdl/line_pixel_stepper.sv @@
// Line pixel stepper: Bresenham line rasterizer for all octants.
// The slave stream carries commands in tuser: a start (tuser 0) loads both
// endpoints and the colour from tdata and yields the first pixel; a step
// (tuser 1) yields the next pixel along the line. Every input transfer gives
// exactly one output transfer, in order. The output tdata carries a pixel
// valid flag, x, y and colour; tlast marks the pixel at the end point, after
// which the block is idle and a step gives an all-zero result. A start while
// a line runs drops that line.
// The result passes through two registers, the decode queue and then the output
// register, before it shows on the master side.
// Throughput: one item per clock, set by the error update in the
// back end; the two-entry queue and the output register keep it going while
// neither side stalls.
// When the receiver stalls the output register holds its result, the queue
// fills, and s_axis_tready drops once both queue entries are taken.
// Reset clears the queue, the output valid flag and the busy flag: the block
// starts idle.
// Depends on lps_pkg, lps_front, lps_queue and lps_back.
module line_pixel_stepper
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: start_x, start_y, end_x, end_y, colour_in (low bits first)
    input  logic [lps_pkg::S_TDATA_WIDTH-1:0]  s_axis_tdata,
    // tuser: command
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: pixel_valid, pixel_x, pixel_y, pixel_colour (low bits first)
    output logic [lps_pkg::M_TDATA_WIDTH-1:0]  m_axis_tdata,
    // tlast: last_pixel
    output logic                               m_axis_tlast
);
    import lps_pkg::*;

    logic      q_full, q_push, q_valid, q_pop;
    lps_item_t push_item, pop_item;

    lps_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    lps_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_item  (pop_item)
    );

    lps_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ hdl/lps_checker.sv @@
// Port checker for the line pixel stepper, bound to the top level.
// Watches only the top-level ports; uses lps_pkg for widths.
module lps_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    // tdata: pixel_valid, pixel_x, pixel_y, pixel_colour (low bits first)
    input logic [lps_pkg::M_TDATA_WIDTH-1:0]  m_axis_tdata,
    // tlast: last_pixel
    input logic                               m_axis_tlast
);
    import lps_pkg::*;

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled output transfer changed");

    a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[0])
        else $error("last flag on an empty result");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata == '0 && !m_axis_tlast)
        else $error("idle step result not all zero");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

endmodule

bind line_pixel_stepper lps_checker u_lps_checker (.*);
